@@ rtl/hidscan_pkg.sv @@
// Shared types and constants for the USB HID configuration descriptor scanner.
// Used by hidscan_parser and usb_hid_config_descriptor_scan_unit; no dependencies.
package hidscan_pkg;

  // Descriptor codes
  localparam logic [7:0] CLASS_HID       = 8'd3;
  localparam logic [7:0] SUBCLASS_NONE   = 8'd0;
  localparam logic [7:0] SUBCLASS_BOOT   = 8'd1;
  localparam logic [7:0] PROTO_NONE      = 8'd0;
  localparam logic [7:0] PROTO_KEYBOARD  = 8'd1;
  localparam logic [7:0] PROTO_MOUSE     = 8'd2;
  localparam logic [7:0] TYPE_INTERFACE  = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT   = 8'd5;
  localparam logic [7:0] IFACE_MIN_LEN   = 8'd9;
  localparam logic [7:0] EP_MIN_LEN      = 8'd7;
  localparam logic [1:0] XFER_INTERRUPT  = 2'd3;
  localparam logic [7:0] EP_NUM_MASK     = 8'h0F;

  // Byte positions inside a descriptor
  localparam logic [7:0] POS_LENGTH      = 8'd0;
  localparam logic [7:0] POS_TYPE        = 8'd1;
  localparam logic [7:0] POS_IF_NUMBER   = 8'd2;
  localparam logic [7:0] POS_IF_CLASS    = 8'd5;
  localparam logic [7:0] POS_IF_SUBCLASS = 8'd6;
  localparam logic [7:0] POS_IF_PROTOCOL = 8'd7;
  localparam logic [7:0] POS_EP_ADDRESS  = 8'd2;
  localparam logic [7:0] POS_EP_ATTR     = 8'd3;
  localparam logic [7:0] POS_EP_MAXP_LO  = 8'd4;
  localparam logic [7:0] POS_EP_MAXP_HI  = 8'd5;
  localparam logic [7:0] POS_EP_INTERVAL = 8'd6;

  // One endpoint slot of the device record
  typedef struct packed {
    logic [7:0]  intv;
    logic [15:0] maxp;
    logic [4:0]  ep;
    logic [7:0]  iface;
  } slot_t;

  // Device record: classification flags plus both slots
  typedef struct packed {
    slot_t sec;
    slot_t pri;
    logic  boot;
    logic  mouse;
    logic  kbd;
  } record_t;

endpackage

@@ rtl/hidscan_parser.sv @@
// Descriptor splitter and HID classifier: per-byte state update and device record.
// Depends on hidscan_pkg.
module hidscan_parser
  import hidscan_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    take,       // process one byte this cycle
  input  logic [7:0] data_byte,
  input  logic    last_byte,
  output record_t rec_next    // record after this byte
);

  logic [7:0]  pos, len, dtype;
  logic        stopped, seen;
  logic [7:0]  if_num, if_class, if_sub, if_proto;
  logic [7:0]  ep_addr, ep_attr, ep_intv;
  logic [15:0] ep_maxp;
  record_t     rec;

  logic [7:0]  pos_next, len_next, dtype_next;
  logic        stopped_next, seen_next;
  logic [7:0]  if_num_next, if_class_next, if_sub_next, if_proto_next;
  logic [7:0]  ep_addr_next, ep_attr_next, ep_intv_next;
  logic [15:0] ep_maxp_next;

  logic        cplt, is_if, is_ep, ep_ok;
  logic        m_kbd, m_comp, m_alone;
  logic [4:0]  ep_idx;
  logic [7:0]  ep_num;

  // Byte placement and completion
  always_comb begin
    pos_next      = pos;
    len_next      = len;
    dtype_next    = dtype;
    stopped_next  = stopped;
    if_num_next   = if_num;
    if_class_next = if_class;
    if_sub_next   = if_sub;
    if_proto_next = if_proto;
    ep_addr_next  = ep_addr;
    ep_attr_next  = ep_attr;
    ep_maxp_next  = ep_maxp;
    ep_intv_next  = ep_intv;
    cplt          = 1'b0;
    if (!stopped) begin
      if (pos == POS_LENGTH) begin
        if (data_byte == 8'd0) begin
          stopped_next = 1'b1;
        end else begin
          len_next   = data_byte;
          dtype_next = 8'd0;
        end
      end else if (pos == POS_TYPE) begin
        dtype_next = data_byte;
      end else if (dtype == TYPE_INTERFACE && len >= IFACE_MIN_LEN) begin
        if (pos == POS_IF_NUMBER)   if_num_next   = data_byte;
        if (pos == POS_IF_CLASS)    if_class_next = data_byte;
        if (pos == POS_IF_SUBCLASS) if_sub_next   = data_byte;
        if (pos == POS_IF_PROTOCOL) if_proto_next = data_byte;
      end else if (dtype == TYPE_ENDPOINT && len >= EP_MIN_LEN) begin
        if (pos == POS_EP_ADDRESS)  ep_addr_next  = data_byte;
        if (pos == POS_EP_ATTR)     ep_attr_next  = data_byte;
        if (pos == POS_EP_MAXP_LO)  ep_maxp_next  = {8'd0, data_byte};
        if (pos == POS_EP_MAXP_HI)  ep_maxp_next  = {data_byte, ep_maxp[7:0]};
        if (pos == POS_EP_INTERVAL) ep_intv_next  = data_byte;
      end
      // zero length byte stops without advancing
      if (!(pos == POS_LENGTH && data_byte == 8'd0)) begin
        if (({1'b0, pos} + 9'd1) >= {1'b0, len_next}) begin
          cplt     = 1'b1;
          pos_next = 8'd0;
        end else begin
          pos_next = pos + 8'd1;
        end
      end
    end
  end

  // Acting on a completed interface or endpoint descriptor
  assign is_if  = (dtype_next == TYPE_INTERFACE) && (len_next >= IFACE_MIN_LEN);
  assign is_ep  = (dtype_next == TYPE_ENDPOINT) && (len_next >= EP_MIN_LEN);
  assign ep_num = ep_addr_next & EP_NUM_MASK;
  assign ep_idx = {ep_num[3:0], 1'b1};
  assign ep_ok  = (if_class_next == CLASS_HID) && ep_addr_next[7]
                  && (ep_attr_next[1:0] == XFER_INTERRUPT);
  assign m_kbd   = rec.kbd && (if_num_next == rec.pri.iface);
  assign m_comp  = rec.mouse && (rec.sec.iface != 8'd0) && (if_num_next == rec.sec.iface);
  assign m_alone = rec.mouse && !rec.kbd && (if_num_next == rec.pri.iface);

  // A complete interface descriptor enables later endpoints
  assign seen_next = seen || (cplt && is_if);

  always_comb begin
    rec_next = rec;
    if (cplt && is_if) begin
      if (if_class_next == CLASS_HID) begin
        if (if_sub_next == SUBCLASS_BOOT && if_proto_next == PROTO_KEYBOARD) begin
          if (!rec.kbd) begin
            rec_next.kbd       = 1'b1;
            rec_next.boot      = 1'b1;
            rec_next.pri.iface = if_num_next;
          end
        end else if (if_sub_next == SUBCLASS_BOOT && if_proto_next == PROTO_MOUSE) begin
          if (!rec.mouse) begin
            rec_next.mouse = 1'b1;
            rec_next.boot  = 1'b1;
            if (rec.kbd) rec_next.sec.iface = if_num_next;
            else         rec_next.pri.iface = if_num_next;
          end
        end else if (if_sub_next == SUBCLASS_NONE && if_proto_next == PROTO_NONE) begin
          if (rec.kbd && !rec.mouse) begin
            rec_next.mouse     = 1'b1;
            rec_next.boot      = 1'b0;
            rec_next.sec.iface = if_num_next;
          end else if (!rec.kbd && !rec.mouse) begin
            rec_next.kbd       = 1'b1;
            rec_next.boot      = 1'b0;
            rec_next.pri.iface = if_num_next;
          end
        end
      end
    end else if (cplt && is_ep && seen && ep_ok) begin
      priority if (m_kbd && rec.pri.ep == 5'd0) begin
        rec_next.pri.ep   = ep_idx;
        rec_next.pri.maxp = ep_maxp_next;
        rec_next.pri.intv = ep_intv_next;
      end else if (m_comp && rec.sec.ep == 5'd0) begin
        rec_next.sec.ep   = ep_idx;
        rec_next.sec.maxp = ep_maxp_next;
        rec_next.sec.intv = ep_intv_next;
      end else if (m_alone && rec.pri.ep == 5'd0) begin
        rec_next.pri.ep   = ep_idx;
        rec_next.pri.maxp = ep_maxp_next;
        rec_next.pri.intv = ep_intv_next;
      end
    end
  end

  // State registers; the last byte returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      pos      <= 8'd0;
      len      <= 8'd0;
      dtype    <= 8'd0;
      stopped  <= 1'b0;
      seen     <= 1'b0;
      if_num   <= 8'd0;
      if_class <= 8'd0;
      if_sub   <= 8'd0;
      if_proto <= 8'd0;
      ep_addr  <= 8'd0;
      ep_attr  <= 8'd0;
      ep_maxp  <= 16'd0;
      ep_intv  <= 8'd0;
      rec      <= '0;
    end else if (take) begin
      pos      <= pos_next;
      len      <= len_next;
      dtype    <= dtype_next;
      stopped  <= stopped_next;
      seen     <= seen_next;
      if_num   <= if_num_next;
      if_class <= if_class_next;
      if_sub   <= if_sub_next;
      if_proto <= if_proto_next;
      ep_addr  <= ep_addr_next;
      ep_attr  <= ep_attr_next;
      ep_maxp  <= ep_maxp_next;
      ep_intv  <= ep_intv_next;
      rec      <= rec_next;
    end
  end

endmodule

@@ rtl/usb_hid_config_descriptor_scan_unit.sv @@
// USB HID configuration descriptor scanner, top level.
// Depends on hidscan_pkg and hidscan_parser.
//
// Usage:
//   Slave side carries the descriptor set one byte per word (s_tdata), with
//   s_tlast on the final byte. Master side returns one 80-bit device record
//   per descriptor set, on the word after the set's last byte.
// Output: a last byte waits in the input register, then its record is loaded
//   into the result register and m_tvalid rises; a full result register can
//   hold the byte in between. Throughput: one byte per cycle unless a last byte
//   is held so; the per-byte descriptor state update is a single combinational
//   pass between the input and state registers.
// Stall: bytes that are not last keep flowing while a record waits on
//   m_tready; a last byte waits in the input register until the result
//   register is free, and s_tready drops meanwhile.
// Reset: rst clears the parse state, the record and both valid flags. The
//   parse state is also cleared after each last byte, ready for the next set.
module usb_hid_config_descriptor_scan_unit
  import hidscan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // keyboard_found, mouse_found, boot_protocol,
                                 // primary_interface[8], primary_endpoint[5],
                                 // primary_max_packet[16], primary_interval[8],
                                 // secondary_interface[8], secondary_endpoint[5],
                                 // secondary_max_packet[16], secondary_interval[8],
                                 // 3 zero pad bits
);

  logic       in_valid, in_last;
  logic [7:0] in_byte;
  logic       out_free, take;
  record_t    rec_next, out_rec;

  // Pipeline advance control
  assign out_free = !m_tvalid || m_tready;
  assign take     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  hidscan_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (in_byte),
    .last_byte (in_last),
    .rec_next  (rec_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      out_rec <= rec_next;
    end
  end

  assign m_tdata = {3'b000,
                    out_rec.sec.intv, out_rec.sec.maxp, out_rec.sec.ep, out_rec.sec.iface,
                    out_rec.pri.intv, out_rec.pri.maxp, out_rec.pri.ep, out_rec.pri.iface,
                    out_rec.boot, out_rec.mouse, out_rec.kbd};

endmodule
